// ----- rtl/bpa_pkg.sv -----
// bitmap page allocator: shared constants, op and status codes,
// and the command/status bundles between controller and datapath
// no dependencies
`default_nettype none

package bpa_pkg;

  // default sizing handed to the top-level parameters
  localparam int DEF_MAX_PAGES = 65536;
  localparam int DEF_WORD_BITS = 64;

  // field widths
  localparam int PAGE_W   = 16;
  localparam int LIMIT_W  = 17;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // pages addressable by the page field
  localparam int FIELD_PAGES = 65536;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr;        // write one all-used word of the clearing pass
    logic take;       // capture the input item and start the divider
    logic rng;        // result: page out of range or bad op
    logic scan_init;  // set up the two search passes
    logic scan;       // one search step: issue a read, check a word
    logic fail;       // result: no free page
    logic rmw_rd;     // read the word holding the input page
    logic rmw_wr;     // update that word and form the result
    logic out_load;   // move the result into the output register
  } bpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            clr_last;
    logic            div_done;
    logic [OP_W-1:0] op;
    logic            out_of_range;
    logic            scan_none;
    logic            chk_valid;
    logic            scan_hit;
    logic            chk_last;
    logic            out_free;
  } bpa_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/bpa_div.sv -----
// two-stage divider by a constant: reciprocal multiply, then one correction
// depends on bpa_pkg
`default_nettype none

module bpa_div import bpa_pkg::*; #(
  parameter int DIVISOR = 64,
  parameter int QW      = 11,
  parameter int RW      = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [LIMIT_W-1:0] dividend,
  output logic                    done,
  output logic      [QW-1:0]      quo,
  output logic      [RW-1:0]      rem
);

  // floor(2^17 / d) underestimates by less than one quotient step
  localparam int RECIP   = (1 << LIMIT_W) / DIVISOR;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = LIMIT_W + RECIP_W;

  logic [PROD_W-1:0]  prod_r;
  logic [LIMIT_W-1:0] val_r;
  logic [1:0]         vld_r;
  logic [QW-1:0]      quo_r;
  logic [RW-1:0]      rem_r;

  logic [LIMIT_W-1:0] q_est;
  logic [LIMIT_W-1:0] q_back;
  logic [LIMIT_W-1:0] diff;
  logic               fix;

  // stage 1: reciprocal product, loaded on start
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(dividend) * PROD_W'(RECIP);
      val_r  <= dividend;
    end
  end

  // stage 2: remainder and single correction step
  always_comb begin
    q_est  = LIMIT_W'(prod_r >> LIMIT_W);
    q_back = q_est * LIMIT_W'(DIVISOR);
    diff   = val_r - q_back;
    fix    = (diff >= LIMIT_W'(DIVISOR));
  end

  // quotient and remainder held until the next start
  always_ff @(posedge clk) begin
    if (vld_r[0]) begin
      if (fix) begin
        quo_r <= QW'(q_est + LIMIT_W'(1));
        rem_r <= RW'(diff - LIMIT_W'(DIVISOR));
      end else begin
        quo_r <= QW'(q_est);
        rem_r <= RW'(diff);
      end
    end
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], start};
    end
  end

  assign done = vld_r[1];
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
// bitmap page allocator controller: sequences clearing, divide, search and
// read-modify-write; depends on bpa_pkg
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bpa_sts_t sts,
  output bpa_cmd_t      cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SETUP  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RMW_RD = 3'd5;
  localparam logic [2:0] S_RMW_WR = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          case (sts.op)
            OP_ALLOC: begin
              state_nxt = S_SETUP;
            end
            OP_FREE, OP_RESERVE: begin
              if (sts.out_of_range) begin
                cmd.rng   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RMW_RD;
              end
            end
            default: begin
              cmd.rng   = 1'b1;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SETUP: begin
        cmd.scan_init = 1'b1;
        if (sts.scan_none) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.chk_valid && sts.scan_hit) begin
          state_nxt = S_DONE;
        end else if (sts.chk_valid && sts.chk_last) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RMW_RD: begin
        cmd.rmw_rd = 1'b1;
        state_nxt  = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/bpa_dpath.sv -----
// bitmap page allocator datapath: limit and hint registers, used-page ram,
// page/word divider, pipelined word search and result registers
// depends on bpa_pkg, bpa_ram, bpa_div
`default_nettype none

module bpa_dpath import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_page_limit,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [PAGE_W-1:0]   in_page_number,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic      [PAGE_W-1:0]   out_page_number_out,
  output logic      [STATUS_W-1:0] out_status,
  input  wire bpa_cmd_t            cmd,
  output bpa_sts_t                 sts
);

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WW        = AW + 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int HW        = BW + 1;
  localparam int LIM_CAP   = (MAX_PAGES < FIELD_PAGES) ? MAX_PAGES : FIELD_PAGES;

  // configuration, item and hint registers
  logic [LIMIT_W-1:0]  limit_r;
  logic [OP_W-1:0]     op_r;
  logic [PAGE_W-1:0]   page_r;
  logic [PAGE_W-1:0]   hint_r;
  logic [WW-1:0]       hint_w_r;
  logic [BW-1:0]       hint_b_r;
  logic [AW-1:0]       clr_w_r;

  // search registers
  logic                p2_ok_r;
  logic [WW-1:0]       p1_last_r;
  logic [WW-1:0]       p2_last_r;
  logic [WW-1:0]       e2_w_r;
  logic [BW-1:0]       e2_b_r;
  logic                iss_act_r;
  logic                iss_pass_r;
  logic [WW-1:0]       iss_w_r;
  logic [LIMIT_W-1:0]  iss_base_r;
  logic [BW-1:0]       iss_lo_r;
  logic                chk_valid_r;
  logic                chk_last_r;
  logic [WW-1:0]       chk_w_r;
  logic [LIMIT_W-1:0]  chk_base_r;
  logic [BW-1:0]       chk_lo_r;
  logic [HW-1:0]       chk_hi_r;

  // result and output registers
  logic [PAGE_W-1:0]   res_page_r;
  logic [STATUS_W-1:0] res_st_r;
  logic                out_valid_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [STATUS_W-1:0] out_st_r;

  // divider
  logic [LIMIT_W-1:0]  eff_lim;
  logic [LIMIT_W-1:0]  dividend;
  logic                div_done;
  logic [WW-1:0]       div_q;
  logic [BW-1:0]       div_r;

  // ram ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // search setup and step logic
  logic                hint_lt;
  logic [WW-1:0]       e2_w;
  logic [BW-1:0]       e2_b;
  logic                p2_ok;
  logic [WW-1:0]       p1_last;
  logic [WW-1:0]       p2_last;
  logic [WW-1:0]       cur_end_w;
  logic [BW-1:0]       cur_end_b;
  logic [WW-1:0]       cur_last;
  logic                at_last;
  logic [HW-1:0]       hi_now;
  logic                final_word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] hit_oh;
  logic [BW-1:0]       hit_idx;
  logic                hit;
  logic [PAGE_W-1:0]   hit_page;

  // free/reserve word update
  logic [WORD_BITS-1:0] bit_oh;
  logic                page_used;
  logic                rmw_write;
  logic                hint_lower;

  // effective limit, capped by the map size and the page field
  assign eff_lim  = (limit_r > LIMIT_W'(LIM_CAP)) ? LIMIT_W'(LIM_CAP) : limit_r;
  assign dividend = (in_op == OP_ALLOC) ? eff_lim : {1'b0, in_page_number};

  bpa_div #(
    .DIVISOR (WORD_BITS),
    .QW      (WW),
    .RW      (BW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.take),
    .dividend (dividend),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pass setup: pass 1 runs hint..limit, pass 2 runs 0..min(hint, limit)
  always_comb begin
    hint_lt = ({1'b0, hint_r} < eff_lim);
    e2_w    = hint_lt ? hint_w_r : div_q;
    e2_b    = hint_lt ? hint_b_r : div_r;
    p2_ok   = (e2_w != '0) || (e2_b != '0);
    p1_last = (div_r == '0) ? (div_q - WW'(1)) : div_q;
    p2_last = (e2_b == '0) ? (e2_w - WW'(1)) : e2_w;
  end

  // issue side: bounds of the word being read
  always_comb begin
    cur_end_w  = iss_pass_r ? e2_w_r : div_q;
    cur_end_b  = iss_pass_r ? e2_b_r : div_r;
    cur_last   = iss_pass_r ? p2_last_r : p1_last_r;
    at_last    = (iss_w_r == cur_last);
    hi_now     = (iss_w_r == cur_end_w) ? {1'b0, cur_end_b} : HW'(WORD_BITS);
    final_word = at_last && (iss_pass_r || !p2_ok_r);
  end

  // check side: lowest free page inside the word's bounds
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BW'(i) >= chk_lo_r) && (HW'(i) < chk_hi_r);
    end
    free_bits = ~ram_rdata & mask;
    hit_oh    = free_bits & (~free_bits + WORD_BITS'(1));
    hit_idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_idx = BW'(i);
      end
    end
    hit      = chk_valid_r && (free_bits != '0);
    hit_page = PAGE_W'(chk_base_r + LIMIT_W'(hit_idx));
  end

  // free/reserve bit update
  always_comb begin
    bit_oh     = WORD_BITS'(1) << div_r;
    page_used  = ram_rdata[div_r];
    rmw_write  = (op_r == OP_RESERVE) || page_used;
    hint_lower = (op_r == OP_FREE) && page_used && (page_r < hint_r);
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_w_r;
    ram_wdata = '1;
    ram_re    = 1'b0;
    ram_raddr = iss_w_r[AW-1:0];
    if (cmd.clr) begin
      ram_we = 1'b1;
    end else if (cmd.scan && hit) begin
      ram_we    = 1'b1;
      ram_waddr = chk_w_r[AW-1:0];
      ram_wdata = ram_rdata | hit_oh;
    end else if (cmd.rmw_wr && rmw_write) begin
      ram_we    = 1'b1;
      ram_waddr = div_q[AW-1:0];
      ram_wdata = (op_r == OP_FREE) ? (ram_rdata & ~bit_oh) : (ram_rdata | bit_oh);
    end
    if (cmd.scan && iss_act_r) begin
      ram_re = 1'b1;
    end else if (cmd.rmw_rd) begin
      ram_re    = 1'b1;
      ram_raddr = div_q[AW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      hint_r      <= '0;
      hint_w_r    <= '0;
      hint_b_r    <= '0;
      clr_w_r     <= '0;
      iss_act_r   <= 1'b0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_page_limit;
      end
      if (cmd.clr) begin
        clr_w_r <= clr_w_r + AW'(1);
      end
      // hint follows the granted page, or drops to a freed page below it
      if (cmd.scan && hit) begin
        hint_r   <= hit_page;
        hint_w_r <= chk_w_r;
        hint_b_r <= hit_idx;
      end else if (cmd.rmw_wr && hint_lower) begin
        hint_r   <= page_r;
        hint_w_r <= div_q;
        hint_b_r <= div_r;
      end
      if (cmd.scan_init) begin
        iss_act_r   <= hint_lt || p2_ok;
        chk_valid_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid_r <= iss_act_r;
        if (iss_act_r && final_word) begin
          iss_act_r <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_op;
      page_r <= in_page_number;
    end
    if (cmd.scan_init) begin
      p2_ok_r   <= p2_ok;
      p1_last_r <= p1_last;
      p2_last_r <= p2_last;
      e2_w_r    <= e2_w;
      e2_b_r    <= e2_b;
      if (hint_lt) begin
        iss_pass_r <= 1'b0;
        iss_w_r    <= hint_w_r;
        iss_base_r <= {1'b0, hint_r} - LIMIT_W'(hint_b_r);
        iss_lo_r   <= hint_b_r;
      end else begin
        iss_pass_r <= 1'b1;
        iss_w_r    <= '0;
        iss_base_r <= '0;
        iss_lo_r   <= '0;
      end
    end else if (cmd.scan && iss_act_r) begin
      chk_w_r    <= iss_w_r;
      chk_base_r <= iss_base_r;
      chk_lo_r   <= iss_lo_r;
      chk_hi_r   <= hi_now;
      chk_last_r <= final_word;
      iss_lo_r   <= '0;
      if (at_last && !iss_pass_r) begin
        iss_pass_r <= 1'b1;
        iss_w_r    <= '0;
        iss_base_r <= '0;
      end else begin
        iss_w_r    <= iss_w_r + WW'(1);
        iss_base_r <= iss_base_r + LIMIT_W'(WORD_BITS);
      end
    end
    // result
    if (cmd.rng) begin
      res_page_r <= page_r;
      res_st_r   <= ST_RANGE;
    end else if (cmd.fail) begin
      res_page_r <= '0;
      res_st_r   <= ST_NO_FREE;
    end else if (cmd.scan && hit) begin
      res_page_r <= hit_page;
      res_st_r   <= ST_OK;
    end else if (cmd.rmw_wr) begin
      res_page_r <= page_r;
      res_st_r   <= (op_r == OP_FREE && !page_used) ? ST_DOUBLE_FREE : ST_OK;
    end
    if (cmd.out_load) begin
      out_page_r <= res_page_r;
      out_st_r   <= res_st_r;
    end
  end

  // status to controller
  always_comb begin
    sts.clr_last     = (clr_w_r == AW'(MAP_WORDS - 1));
    sts.div_done     = div_done;
    sts.op           = op_r;
    sts.out_of_range = ({1'b0, page_r} >= eff_lim);
    sts.scan_none    = !hint_lt && !p2_ok;
    sts.chk_valid    = chk_valid_r;
    sts.scan_hit     = hit;
    sts.chk_last     = chk_last_r;
    sts.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_page_number_out = out_page_r;
  assign out_status          = out_st_r;

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
// Bitmap page allocator with a next-fit search hint.
// Input channel (in_valid/in_stall): in_op selects allocate, free or reserve;
// in_page_number is the page to free or reserve. Result channel
// (out_valid/out_stall): out_page_number_out is the granted or echoed page,
// out_status is ok, no free page, already free, or out of range.
// cfg_we writes cfg_page_limit, the count of pages in range; write it only
// while the block is idle.
// After reset every page reads as used: a clearing pass writes the map one
// word a cycle, with in_stall held high. One item at a time. Free and
// reserve pass through the divider, then read and write the page's map
// word; an out-of-range page or a bad op goes from the divider straight to
// the result. Allocate passes through the divider and the search setup,
// then reads map words from the hint word up to the limit, then word zero
// up to the hint, and fails at the setup when no page is in range. The
// search reads one map word per cycle from the single ram read port. A
// finished result sits in the output register while the next item is taken;
// a stalled result holds and only delays the loading of the following one.
// depends on bpa_pkg, bpa_ctrl, bpa_dpath
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_page_limit,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [PAGE_W-1:0]   in_page_number,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [PAGE_W-1:0]   out_page_number_out,
  output logic      [STATUS_W-1:0] out_status
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_page_limit      (cfg_page_limit),
    .in_op               (in_op),
    .in_page_number      (in_page_number),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_page_number_out (out_page_number_out),
    .out_status          (out_status),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  // one item in flight: a transfer closes the input side next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // divider done only follows a matching take, through its valid pipe
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> $past(cmd.take, 2))
    else $error("divider result without a matching start");

endmodule

`default_nettype wire
